[rtl/grid_widest_path_defines.svh]
// ----------------------------------------------------------------------------
// grid_widest_path assertion macros
// Shared concurrent assertion forms for the grid widest path block.
// ----------------------------------------------------------------------------
`ifndef GRID_WIDEST_PATH_DEFINES_SVH
`define GRID_WIDEST_PATH_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define GWP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Invariant checked on every clock edge outside reset.
`define GWP_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

[rtl/gwp_pkg.sv]
// ----------------------------------------------------------------------------
// gwp_pkg
// Constants, register indexes and control structs of the grid widest path block.
// ----------------------------------------------------------------------------
package gwp_pkg;

    localparam int DEF_MAX_ROWS   = 32;
    localparam int DEF_MAX_COLS   = 32;
    localparam int DEF_HEAP_DEPTH = 4096;

    localparam int VAL_W = 16;   // cell value width
    localparam int CFG_W = 6;    // configuration register width
    localparam int IDX_W = 1;    // configuration register index width

    localparam logic [IDX_W-1:0] REG_ROW_COUNT = 1'd0;
    localparam logic [IDX_W-1:0] REG_COL_COUNT = 1'd1;

    // requests from the search sequencer to the heap unit
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } heap_req_t;

    typedef struct packed {
        logic busy;
        logic empty;
    } heap_rsp_t;

    // search sequencer status towards the top level
    typedef struct packed {
        logic busy;
        logic done;
    } srch_rsp_t;

endpackage

[rtl/gwp_ram.sv]
// ----------------------------------------------------------------------------
// gwp_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module gwp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/gwp_heap.sv]
// ----------------------------------------------------------------------------
// gwp_heap
// Binary max-heap in RAM; push sifts up, pop sifts down, one shared comparator.
// ----------------------------------------------------------------------------
`include "grid_widest_path_defines.svh"

module gwp_heap #(
    parameter int HEAP_DEPTH = gwp_pkg::DEF_HEAP_DEPTH,
    parameter int KEY_W      = 26
) (
    input  logic              clk,
    input  logic              rst_n,
    input  gwp_pkg::heap_req_t req,
    input  logic [KEY_W-1:0]  push_key,
    output gwp_pkg::heap_rsp_t rsp,
    output logic [KEY_W-1:0]  pop_key
);

    import gwp_pkg::*;

    localparam int HW  = $clog2(HEAP_DEPTH);
    localparam int SW  = HW + 1;
    localparam int IXW = HW + 2;

    localparam logic [2:0] H_IDLE     = 3'd0;
    localparam logic [2:0] H_UP_CHK   = 3'd1;
    localparam logic [2:0] H_UP_CMP   = 3'd2;
    localparam logic [2:0] H_POP_TOP  = 3'd3;
    localparam logic [2:0] H_POP_LAST = 3'd4;
    localparam logic [2:0] H_DN_L     = 3'd5;
    localparam logic [2:0] H_DN_R     = 3'd6;
    localparam logic [2:0] H_DN_CMP   = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [SW-1:0]    size_reg, size_next;
    logic [HW-1:0]    idx_reg, idx_next;
    logic [KEY_W-1:0] hole_reg, hole_next;
    logic [KEY_W-1:0] best_reg, best_next;
    logic             pick_reg, pick_next;
    logic [KEY_W-1:0] pop_key_reg, pop_key_next;

    logic             we;
    logic [HW-1:0]    waddr, raddr;
    logic [KEY_W-1:0] wdata, rdata;

    logic [IXW-1:0]   lchild, rchild;
    logic [HW-1:0]    parent;
    logic             l_in, r_in;
    logic [KEY_W-1:0] cmp_a, cmp_b;
    logic             cmp_gt;

    gwp_ram #(
        .WIDTH (KEY_W),
        .DEPTH (HEAP_DEPTH)
    ) u_heap_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign lchild = IXW'({idx_reg, 1'b1});
    assign rchild = lchild + IXW'(1);
    assign parent = HW'((idx_reg - HW'(1)) >> 1);
    assign l_in   = lchild < IXW'(size_reg);
    assign r_in   = rchild < IXW'(size_reg);
    assign cmp_gt = cmp_a > cmp_b;

    always_comb
    begin
        state_next   = state_reg;
        size_next    = size_reg;
        idx_next     = idx_reg;
        hole_next    = hole_reg;
        best_next    = best_reg;
        pick_next    = pick_reg;
        pop_key_next = pop_key_reg;
        we           = 1'b0;
        waddr        = idx_reg;
        wdata        = hole_reg;
        raddr        = '0;
        cmp_a        = hole_reg;
        cmp_b        = rdata;
        case (state_reg)
            H_IDLE:
            begin
                if (req.clear)
                begin
                    size_next = '0;
                end
                else if (req.push)
                begin
                    // a push onto a full heap is dropped
                    if (size_reg < SW'(HEAP_DEPTH))
                    begin
                        hole_next  = push_key;
                        idx_next   = size_reg[HW-1:0];
                        size_next  = size_reg + SW'(1);
                        state_next = H_UP_CHK;
                    end
                end
                else if (req.pop)
                begin
                    state_next = H_POP_TOP;
                end
            end
            H_UP_CHK:
            begin
                if (idx_reg == '0)
                begin
                    we         = 1'b1;
                    state_next = H_IDLE;
                end
                else
                begin
                    raddr      = parent;
                    state_next = H_UP_CMP;
                end
            end
            H_UP_CMP:
            begin
                we = 1'b1;
                if (cmp_gt)
                begin
                    wdata      = rdata;
                    idx_next   = parent;
                    state_next = H_UP_CHK;
                end
                else
                begin
                    state_next = H_IDLE;
                end
            end
            H_POP_TOP:
            begin
                pop_key_next = rdata;
                size_next    = size_reg - SW'(1);
                raddr        = HW'(size_reg - SW'(1));
                state_next   = H_POP_LAST;
            end
            H_POP_LAST:
            begin
                hole_next  = rdata;
                idx_next   = '0;
                state_next = H_DN_L;
            end
            H_DN_L:
            begin
                if (!l_in)
                begin
                    we         = 1'b1;
                    state_next = H_IDLE;
                end
                else
                begin
                    raddr      = lchild[HW-1:0];
                    state_next = H_DN_R;
                end
            end
            H_DN_R:
            begin
                cmp_a     = rdata;
                cmp_b     = hole_reg;
                pick_next = cmp_gt;
                best_next = cmp_gt ? rdata : hole_reg;
                if (r_in)
                begin
                    raddr = rchild[HW-1:0];
                end
                state_next = H_DN_CMP;
            end
            H_DN_CMP:
            begin
                cmp_a = rdata;
                cmp_b = best_reg;
                we    = 1'b1;
                if (r_in && cmp_gt)
                begin
                    wdata      = rdata;
                    idx_next   = rchild[HW-1:0];
                    state_next = H_DN_L;
                end
                else if (pick_reg)
                begin
                    wdata      = best_reg;
                    idx_next   = lchild[HW-1:0];
                    state_next = H_DN_L;
                end
                else
                begin
                    state_next = H_IDLE;
                end
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            size_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        hole_reg    <= hole_next;
        best_reg    <= best_next;
        pick_reg    <= pick_next;
        pop_key_reg <= pop_key_next;
    end

    assign rsp.busy  = state_reg != H_IDLE;
    assign rsp.empty = size_reg == '0;
    assign pop_key   = pop_key_reg;

    `GWP_ASSERT_IMP(a_req_when_idle, clk, rst_n, (req.push || req.pop), (state_reg == H_IDLE), "heap request while busy")
    `GWP_ASSERT_IMP(a_pop_not_empty, clk, rst_n, req.pop, (size_reg != '0), "pop from empty heap")
    `GWP_ASSERT_ALWAYS(a_size_bound, clk, rst_n, (size_reg <= SW'(HEAP_DEPTH)), "heap size overflow")

endmodule

[rtl/gwp_search.sv]
// ----------------------------------------------------------------------------
// gwp_search
// Best-first widest path sequencer: clears the best table, seeds the heap,
// then pops cells and relaxes their four neighbours until the target is hit or the heap runs empty.
// ----------------------------------------------------------------------------
module gwp_search #(
    parameter int MAX_ROWS   = gwp_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS   = gwp_pkg::DEF_MAX_COLS,
    parameter int HEAP_DEPTH = gwp_pkg::DEF_HEAP_DEPTH
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic [$clog2(MAX_ROWS):0]                 rows,
    input  logic [$clog2(MAX_COLS):0]                 cols,
    input  logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]      last,
    output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]      grid_raddr,
    input  logic [gwp_pkg::VAL_W-1:0]                 grid_rdata,
    input  logic                                      take,
    output gwp_pkg::srch_rsp_t                        rsp,
    output logic [gwp_pkg::VAL_W-1:0]                 score
);

    import gwp_pkg::*;

    localparam int RW       = $clog2(MAX_ROWS);
    localparam int CW       = $clog2(MAX_COLS);
    localparam int RCNT_W   = RW + 1;
    localparam int CCNT_W   = CW + 1;
    localparam int CELL_CAP = MAX_ROWS * MAX_COLS;
    localparam int CELL_W   = $clog2(CELL_CAP);
    localparam int KEY_W    = VAL_W + RW + CW;
    localparam int BW       = VAL_W + 1;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CLR       = 4'd1;
    localparam logic [3:0] S_SEED_RD   = 4'd2;
    localparam logic [3:0] S_SEED      = 4'd3;
    localparam logic [3:0] S_POP       = 4'd4;
    localparam logic [3:0] S_POP_WAIT  = 4'd5;
    localparam logic [3:0] S_IDX       = 4'd6;
    localparam logic [3:0] S_BEST_RD   = 4'd7;
    localparam logic [3:0] S_BEST_CHK  = 4'd8;
    localparam logic [3:0] S_NB        = 4'd9;
    localparam logic [3:0] S_NB_CMP    = 4'd10;
    localparam logic [3:0] S_PUSH_WAIT = 4'd11;
    localparam logic [3:0] S_FIN_RD    = 4'd12;
    localparam logic [3:0] S_FIN       = 4'd13;
    localparam logic [3:0] S_DONE      = 4'd14;

    localparam logic [1:0] DIR_DOWN  = 2'd0;
    localparam logic [1:0] DIR_UP    = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    logic [3:0]        state_reg, state_next;
    logic [CELL_W-1:0] ptr_reg, ptr_next;
    logic [VAL_W-1:0]  score_reg, score_next;
    logic [RW-1:0]     r_reg, r_next;
    logic [CW-1:0]     c_reg, c_next;
    logic [1:0]        dir_reg, dir_next;
    logic [CELL_W-1:0] ni_reg, ni_next;
    logic [RW-1:0]     nr_reg, nr_next;
    logic [CW-1:0]     nc_reg, nc_next;
    logic [VAL_W-1:0]  result_reg, result_next;

    heap_req_t         hreq;
    heap_rsp_t         hrsp;
    logic [KEY_W-1:0]  push_key, pop_key;

    logic              best_we;
    logic [CELL_W-1:0] best_waddr, best_raddr;
    logic [BW-1:0]     best_wdata, best_rdata;

    logic [RW+CCNT_W-1:0] row_base;
    logic                 nb_ok;
    logic [CELL_W-1:0]    nb_idx;
    logic [RW-1:0]        nb_r;
    logic [CW-1:0]        nb_c;
    logic [VAL_W-1:0]     cand;

    gwp_heap #(
        .HEAP_DEPTH (HEAP_DEPTH),
        .KEY_W      (KEY_W)
    ) u_heap (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (hreq),
        .push_key (push_key),
        .rsp      (hrsp),
        .pop_key  (pop_key)
    );

    // per-cell best bottleneck: top bit marks a value present
    gwp_ram #(
        .WIDTH (BW),
        .DEPTH (CELL_CAP)
    ) u_best_ram (
        .clk   (clk),
        .we    (best_we),
        .waddr (best_waddr),
        .wdata (best_wdata),
        .raddr (best_raddr),
        .rdata (best_rdata)
    );

    assign row_base = r_reg * cols;
    assign cand     = (grid_rdata < score_reg) ? grid_rdata : score_reg;

    // neighbour of the current cell in direction dir_reg
    always_comb
    begin
        nb_ok  = 1'b0;
        nb_idx = ptr_reg;
        nb_r   = r_reg;
        nb_c   = c_reg;
        case (dir_reg)
            DIR_DOWN:
            begin
                nb_ok  = (RCNT_W'(r_reg) + RCNT_W'(1)) < rows;
                nb_idx = ptr_reg + CELL_W'(cols);
                nb_r   = r_reg + RW'(1);
            end
            DIR_UP:
            begin
                nb_ok  = r_reg != '0;
                nb_idx = ptr_reg - CELL_W'(cols);
                nb_r   = r_reg - RW'(1);
            end
            DIR_RIGHT:
            begin
                nb_ok  = (CCNT_W'(c_reg) + CCNT_W'(1)) < cols;
                nb_idx = ptr_reg + CELL_W'(1);
                nb_c   = c_reg + CW'(1);
            end
            DIR_LEFT:
            begin
                nb_ok  = c_reg != '0;
                nb_idx = ptr_reg - CELL_W'(1);
                nb_c   = c_reg - CW'(1);
            end
            default:
            begin
                nb_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        score_next  = score_reg;
        r_next      = r_reg;
        c_next      = c_reg;
        dir_next    = dir_reg;
        ni_next     = ni_reg;
        nr_next     = nr_reg;
        nc_next     = nc_reg;
        result_next = result_reg;
        hreq        = '0;
        push_key    = {cand, nr_reg, nc_reg};
        best_we     = 1'b0;
        best_waddr  = ni_reg;
        best_wdata  = {1'b1, cand};
        best_raddr  = ptr_reg;
        grid_raddr  = ni_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    hreq.clear = 1'b1;
                    ptr_next   = '0;
                    state_next = S_CLR;
                end
            end
            S_CLR:
            begin
                best_we    = 1'b1;
                best_waddr = ptr_reg;
                best_wdata = '0;
                if (ptr_reg == last)
                begin
                    state_next = S_SEED_RD;
                end
                else
                begin
                    ptr_next = ptr_reg + CELL_W'(1);
                end
            end
            S_SEED_RD:
            begin
                grid_raddr = '0;
                state_next = S_SEED;
            end
            S_SEED:
            begin
                best_we    = 1'b1;
                best_waddr = '0;
                best_wdata = {1'b1, grid_rdata};
                hreq.push  = 1'b1;
                push_key   = {grid_rdata, RW'(0), CW'(0)};
                dir_next   = DIR_LEFT;
                state_next = S_PUSH_WAIT;
            end
            S_POP:
            begin
                if (hrsp.empty)
                begin
                    state_next = S_FIN_RD;
                end
                else
                begin
                    hreq.pop   = 1'b1;
                    state_next = S_POP_WAIT;
                end
            end
            S_POP_WAIT:
            begin
                if (!hrsp.busy)
                begin
                    score_next = pop_key[KEY_W-1 -: VAL_W];
                    r_next     = pop_key[RW+CW-1 -: RW];
                    c_next     = pop_key[CW-1:0];
                    state_next = S_IDX;
                end
            end
            S_IDX:
            begin
                ptr_next   = CELL_W'(row_base) + CELL_W'(c_reg);
                state_next = S_BEST_RD;
            end
            S_BEST_RD:
            begin
                state_next = S_BEST_CHK;
            end
            S_BEST_CHK:
            begin
                // stale entry: a better bottleneck was already recorded
                if (best_rdata[VAL_W] && (score_reg < best_rdata[VAL_W-1:0]))
                begin
                    state_next = S_POP;
                end
                else if (ptr_reg == last)
                begin
                    result_next = score_reg;
                    state_next  = S_DONE;
                end
                else
                begin
                    dir_next   = DIR_DOWN;
                    state_next = S_NB;
                end
            end
            S_NB:
            begin
                grid_raddr = nb_idx;
                best_raddr = nb_idx;
                if (nb_ok)
                begin
                    ni_next    = nb_idx;
                    nr_next    = nb_r;
                    nc_next    = nb_c;
                    state_next = S_NB_CMP;
                end
                else if (dir_reg == DIR_LEFT)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    dir_next = dir_reg + 2'd1;
                end
            end
            S_NB_CMP:
            begin
                if (!best_rdata[VAL_W] || (cand > best_rdata[VAL_W-1:0]))
                begin
                    best_we    = 1'b1;
                    hreq.push  = 1'b1;
                    state_next = S_PUSH_WAIT;
                end
                else if (dir_reg == DIR_LEFT)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    dir_next   = dir_reg + 2'd1;
                    state_next = S_NB;
                end
            end
            S_PUSH_WAIT:
            begin
                if (!hrsp.busy)
                begin
                    if (dir_reg == DIR_LEFT)
                    begin
                        state_next = S_POP;
                    end
                    else
                    begin
                        dir_next   = dir_reg + 2'd1;
                        state_next = S_NB;
                    end
                end
            end
            S_FIN_RD:
            begin
                best_raddr = last;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                result_next = best_rdata[VAL_W] ? best_rdata[VAL_W-1:0] : '0;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        score_reg  <= score_next;
        r_reg      <= r_next;
        c_reg      <= c_next;
        dir_reg    <= dir_next;
        ni_reg     <= ni_next;
        nr_reg     <= nr_next;
        nc_reg     <= nc_next;
        result_reg <= result_next;
    end

    assign rsp.busy = state_reg != S_IDLE;
    assign rsp.done = state_reg == S_DONE;
    assign score    = result_reg;

endmodule

[rtl/grid_widest_path.sv]
// ----------------------------------------------------------------------------
// grid_widest_path
// Loads a grid of cell values and returns the widest (maximum bottleneck)
// path score from the top-left to the bottom-right cell.
// ----------------------------------------------------------------------------
// Cells are taken one per cycle in row-major order while in_ready is high. The
// last cell of the grid starts a search that holds in_ready low until its
// result is taken: a clearing pass over the best-score memory, then for each
// popped heap entry a sift-down of the heap, a look at each neighbour on the
// grid and a sift-up push for each neighbour whose best bottleneck improves.
// All heap work goes through one heap memory port and one key comparator.
// The result waits in an output register; loading of the next grid goes on
// meanwhile. Counts of zero act as one and counts above the maximum saturate.
module grid_widest_path #(
    parameter int MAX_ROWS   = gwp_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS   = gwp_pkg::DEF_MAX_COLS,
    parameter int HEAP_DEPTH = gwp_pkg::DEF_HEAP_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [gwp_pkg::IDX_W-1:0]   wr_index,
    input  logic [gwp_pkg::CFG_W-1:0]   wr_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [gwp_pkg::VAL_W-1:0]   cell_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [gwp_pkg::VAL_W-1:0]   best_score
);

    import gwp_pkg::*;

    localparam int RW       = $clog2(MAX_ROWS);
    localparam int CW       = $clog2(MAX_COLS);
    localparam int RCNT_W   = RW + 1;
    localparam int CCNT_W   = CW + 1;
    localparam int CELL_CAP = MAX_ROWS * MAX_COLS;
    localparam int CELL_W   = $clog2(CELL_CAP);
    localparam int EXT_W    = CFG_W + 1;

    logic [CFG_W-1:0]  row_count_reg, row_count_next;
    logic [CFG_W-1:0]  col_count_reg, col_count_next;
    logic [CELL_W-1:0] load_index_reg, load_index_next;
    logic              out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]  best_score_reg, best_score_next;

    logic [RCNT_W-1:0]        rows;
    logic [CCNT_W-1:0]        cols;
    logic [RCNT_W+CCNT_W-1:0] cell_count;
    logic [CELL_W-1:0]        last;
    logic                     in_fire;
    logic                     grid_end;
    logic                     take;

    logic [CELL_W-1:0] grid_raddr;
    logic [VAL_W-1:0]  grid_rdata;
    srch_rsp_t         srsp;
    logic [VAL_W-1:0]  srch_score;

    always_comb
    begin
        if (row_count_reg == '0)
        begin
            rows = RCNT_W'(1);
        end
        else if (EXT_W'(row_count_reg) > EXT_W'(MAX_ROWS))
        begin
            rows = RCNT_W'(MAX_ROWS);
        end
        else
        begin
            rows = RCNT_W'(row_count_reg);
        end
        if (col_count_reg == '0)
        begin
            cols = CCNT_W'(1);
        end
        else if (EXT_W'(col_count_reg) > EXT_W'(MAX_COLS))
        begin
            cols = CCNT_W'(MAX_COLS);
        end
        else
        begin
            cols = CCNT_W'(col_count_reg);
        end
    end

    assign cell_count = rows * cols;
    assign last       = CELL_W'(cell_count - (RCNT_W + CCNT_W)'(1));
    assign in_ready   = !srsp.busy;
    assign in_fire    = in_valid && in_ready;
    assign grid_end   = load_index_reg >= last;
    assign take       = srsp.done && (!out_valid_reg || out_ready);

    gwp_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CELL_CAP)
    ) u_grid_ram (
        .clk   (clk),
        .we    (in_fire),
        .waddr (load_index_reg),
        .wdata (cell_value),
        .raddr (grid_raddr),
        .rdata (grid_rdata)
    );

    gwp_search #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_search (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_fire && grid_end),
        .rows       (rows),
        .cols       (cols),
        .last       (last),
        .grid_raddr (grid_raddr),
        .grid_rdata (grid_rdata),
        .take       (take),
        .rsp        (srsp),
        .score      (srch_score)
    );

    always_comb
    begin
        row_count_next  = row_count_reg;
        col_count_next  = col_count_reg;
        load_index_next = load_index_reg;
        out_valid_next  = out_valid_reg;
        best_score_next = best_score_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_ROW_COUNT: row_count_next = wr_data;
                REG_COL_COUNT: col_count_next = wr_data;
                default:       row_count_next = row_count_reg;
            endcase
        end
        if (in_fire)
        begin
            load_index_next = grid_end ? '0 : load_index_reg + CELL_W'(1);
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (take)
        begin
            out_valid_next  = 1'b1;
            best_score_next = srch_score;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg  <= CFG_W'(1);
            col_count_reg  <= CFG_W'(1);
            load_index_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            row_count_reg  <= row_count_next;
            col_count_reg  <= col_count_next;
            load_index_reg <= load_index_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_score_reg <= best_score_next;
    end

    assign out_valid  = out_valid_reg;
    assign best_score = best_score_reg;

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Streams grids of cell values into grid_widest_path, predicts the widest
// path score of each grid and checks every returned score in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gwp_pkg::*;

    localparam int CELLS     = DEF_MAX_ROWS * DEF_MAX_COLS;
    localparam int LIMIT     = 1500000;
    localparam int SETTLE    = 40;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    logic             clk;
    logic             rst_n;
    logic             wr_en;
    logic [IDX_W-1:0] wr_index;
    logic [CFG_W-1:0] wr_data;
    logic             in_valid;
    logic             in_ready;
    logic [VAL_W-1:0] cell_value;
    logic             out_valid;
    logic             out_ready;
    logic [VAL_W-1:0] best_score;

    grid_widest_path uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cell_value (cell_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .best_score (best_score)
    );

    logic [VAL_W-1:0] cell_queue[$];
    logic [VAL_W-1:0] score_queue[$];
    logic [VAL_W-1:0] grid_copy[CELLS];
    int               load_pos;
    int               rows_used;
    int               cols_used;
    idle_mode_t       idle_mode;
    int               errors;
    int               cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int clamp_count(input logic [CFG_W-1:0] raw, input int maxv);
        if (raw == 0)
            return 1;
        return (raw > maxv) ? maxv : int'(raw);
    endfunction

    // best-first widest path over the loaded grid
    function automatic logic [VAL_W-1:0] widest_score(input int rows, input int cols);
        int best[CELLS];
        bit done[CELLS];
        int target;
        int u;
        int r;
        int c;
        int n;
        int cand;
        target = rows * cols - 1;
        for (int k = 0; k < CELLS; k++)
        begin
            best[k] = -1;
            done[k] = 1'b0;
        end
        best[0] = grid_copy[0];
        forever
        begin
            u = -1;
            for (int k = 0; k <= target; k++)
                if (!done[k] && best[k] >= 0 && (u < 0 || best[k] > best[u]))
                    u = k;
            if (u < 0)
                break;
            if (u == target)
                return best[u][VAL_W-1:0];
            done[u] = 1'b1;
            r = u / cols;
            c = u % cols;
            for (int d = 0; d < 4; d++)
            begin
                n = -1;
                if (d == 0 && r + 1 < rows) n = u + cols;
                if (d == 1 && r > 0)        n = u - cols;
                if (d == 2 && c + 1 < cols) n = u + 1;
                if (d == 3 && c > 0)        n = u - 1;
                if (n >= 0)
                begin
                    cand = (grid_copy[n] < best[u]) ? grid_copy[n] : best[u];
                    if (cand > best[n])
                        best[n] = cand;
                end
            end
        end
        return (best[target] < 0) ? '0 : best[target][VAL_W-1:0];
    endfunction

    task automatic report_mismatch(input logic [VAL_W-1:0] got, input logic [VAL_W-1:0] want,
                                   input bit stray);
        if (stray)
            $display("mismatch: score %0d with no grid outstanding", got);
        else
            $display("mismatch: best_score %0d, predicted %0d", got, want);
        errors++;
    endtask

    // cell driver, predictor runs on each completed grid
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            cell_value <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                grid_copy[load_pos] = cell_value;
                if (load_pos >= rows_used * cols_used - 1)
                begin
                    load_pos = 0;
                    score_queue.push_back(widest_score(rows_used, cols_used));
                end
                else
                    load_pos++;
            end
            if (!in_valid || in_ready)
            begin
                if (cell_queue.size() > 0 &&
                    !((idle_mode == IDLE_SEND && $urandom_range(99) < 85) ||
                      (idle_mode == IDLE_BOTH && $urandom_range(99) < 24)))
                begin
                    in_valid   <= 1'b1;
                    cell_value <= cell_queue.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // score monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (score_queue.size() == 0)
                    report_mismatch(best_score, '0, 1'b1);
                else if (best_score !== score_queue[0])
                    report_mismatch(best_score, score_queue.pop_front(), 1'b0);
                else
                    void'(score_queue.pop_front());
            end
            out_ready <= !((idle_mode == IDLE_RECV && $urandom_range(99) < 85) ||
                           (idle_mode == IDLE_BOTH && $urandom_range(99) < 24));
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic wait_idle();
        while (cell_queue.size() > 0 || in_valid || score_queue.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_counts(input logic [CFG_W-1:0] raw_rows, input logic [CFG_W-1:0] raw_cols);
        wait_idle();
        wr_en    <= 1'b1;
        wr_index <= REG_ROW_COUNT;
        wr_data  <= raw_rows;
        @(posedge clk);
        wr_index <= REG_COL_COUNT;
        wr_data  <= raw_cols;
        @(posedge clk);
        wr_en <= 1'b0;
        rows_used = clamp_count(raw_rows, DEF_MAX_ROWS);
        cols_used = clamp_count(raw_cols, DEF_MAX_COLS);
    endtask

    function automatic logic [VAL_W-1:0] pick_cell(input int style);
        case (style)
            0: return VAL_W'($urandom);
            1: return VAL_W'($urandom_range(7));
            2: return ($urandom_range(3) == 0) ? '0 : VAL_W'($urandom_range(65535, 60000));
            default: return $urandom_range(1) ? '1 : '0;
        endcase
    endfunction

    task automatic queue_grids(input int count);
        int style;
        for (int g = 0; g < count; g++)
        begin
            style = $urandom_range(3);
            for (int k = 0; k < rows_used * cols_used; k++)
                cell_queue.push_back(pick_cell(style));
        end
    endtask

    function automatic logic [CFG_W-1:0] pick_raw();
        int p;
        p = $urandom_range(9);
        if (p == 0) return '0;
        if (p == 1) return CFG_W'($urandom_range(63, 33));
        return CFG_W'($urandom_range(6, 1));
    endfunction

    initial
    begin
        int sent;
        int phase;
        rst_n     = 1'b0;
        wr_en     = 1'b0;
        wr_index  = REG_ROW_COUNT;
        wr_data   = '0;
        errors    = 0;
        cycles    = 0;
        load_pos  = 0;
        rows_used = 1;
        cols_used = 1;
        idle_mode = IDLE_NONE;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-cell grids at reset counts, then zero counts acting as one
        cell_queue.push_back('0);
        cell_queue.push_back('1);
        set_counts('0, '0);
        cell_queue.push_back(16'h5a5a);
        set_counts(2, 2);
        cell_queue = '{16'hffff, 16'h0000, 16'h0000, 16'hffff};
        cell_queue.push_back('1); cell_queue.push_back(16'd1);
        cell_queue.push_back('1); cell_queue.push_back('1);
        set_counts(2, 3);
        cell_queue.push_back(16'h8000); cell_queue.push_back(16'h0001);
        cell_queue.push_back(16'h7fff); cell_queue.push_back(16'hfffe);
        cell_queue.push_back(16'h0000); cell_queue.push_back(16'hffff);

        sent  = 0;
        phase = 0;
        while (sent < 600)
        begin
            set_counts(pick_raw(), pick_raw());
            idle_mode = idle_mode_t'(phase % 4);
            queue_grids(4);
            sent += 4 * rows_used * cols_used;
            phase++;
        end
        // saturated thin grids and the full grid
        set_counts(63, 1);
        idle_mode = IDLE_BOTH;
        queue_grids(2);
        set_counts(1, 40);
        idle_mode = IDLE_RECV;
        queue_grids(2);
        set_counts(32, 32);
        idle_mode = IDLE_NONE;
        queue_grids(1);
        wait_idle();

        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
